@@ design/mandelbrot_escape_pixel_unit_defines.svh @@
// assertion macros for the mandelbrot escape pixel unit
`ifndef MANDELBROT_ESCAPE_PIXEL_UNIT_DEFINES_SVH
`define MANDELBROT_ESCAPE_PIXEL_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define MEP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mep assertion failed");

// next-cycle implication under reset
`define MEP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mep assertion failed");

`endif

@@ design/mep_pkg.sv @@
// shared constants, types and codes for the mandelbrot escape pixel unit
package mep_pkg;

  localparam int FRAC_BITS = 28;
  localparam int DIM_BITS  = 12;
  localparam int ITER_BITS = 12;

  // fixed widths of the configuration data and register index fields
  localparam int CFG_W = 13;
  localparam int IDX_W = 2;

  // z components: sign, 4 integer bits, fraction
  localparam int Z_W   = FRAC_BITS + 5;
  // magnitudes fed to the shared multiplier
  localparam int MAG_W = Z_W - 1;
  // truncated product magnitude and signed product
  localparam int T_W   = 2 * MAG_W - FRAC_BITS;
  localparam int P_W   = T_W + 1;
  // divider widths
  localparam int NUM_W = FRAC_BITS + DIM_BITS + 2;
  localparam int DEN_W = CFG_W;
  localparam int Q_W   = FRAC_BITS + 2;
  localparam int STEP_W = $clog2(NUM_W + 1);
  localparam int CNT_W = ITER_BITS + 1;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_LIMIT  = 2'd2;

  typedef enum logic [1:0] {DIV_X, DIV_Y, DIV_SCALE} div_sel_t;
  typedef enum logic [1:0] {MUL_RR, MUL_II, MUL_RI} mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DX, ST_DXW, ST_DY, ST_DYW, ST_IR, ST_II, ST_RI, ST_UP,
    ST_SC, ST_SCW, ST_FIN
  } state_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     store_x;
    logic     store_y;
    logic     z_update;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic escape;
    logic count_full;
  } status_t;

endpackage

@@ design/mep_div.sv @@
// restoring divider, one quotient bit per cycle
module mep_div import mep_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  logic [NUM_W-1:0]  quot_r;
  logic [DEN_W-1:0]  rem_r, den_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r, done_r;
  logic [DEN_W:0]    shifted;
  logic              fits;

  // one restoring step
  assign shifted = {rem_r, quot_r[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(NUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath of the divider
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= num;
      den_r  <= den;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
      quot_r <= {quot_r[NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

@@ design/mep_datapath.sv @@
// registers, multiplier and divider of the escape-time computation
module mep_datapath import mep_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic [DIM_BITS-1:0] in_pixel_column,
  input  logic [DIM_BITS-1:0] in_pixel_row,
  input  cmd_t                cmd,
  output status_t             status,
  output logic [7:0]          out_gray_level
);

  localparam logic [CFG_W-1:0] DIM_CAP  = CFG_W'(1 << DIM_BITS);
  localparam logic [CFG_W-1:0] ITER_CAP = CFG_W'(1 << ITER_BITS);
  localparam logic signed [Z_W-1:0] CR_BASE = -(Z_W'(2) <<< FRAC_BITS);
  localparam logic signed [Z_W-1:0] CI_BASE = -(Z_W'(3) <<< (FRAC_BITS - 1));
  localparam logic signed [P_W:0]   BOUND   = (P_W+1)'(4) <<< FRAC_BITS;

  logic [CFG_W-1:0] width_r, height_r, limit_r;
  logic [DIM_BITS-1:0] col_r, row_r;
  logic signed [Z_W-1:0] cr_r, ci_r, zr_r, zi_r;
  logic signed [P_W-1:0] rr_r, ii_r, ri_r;
  logic [CNT_W-1:0] count_r;
  logic [7:0] gray_r;
  logic div_done, escape, count_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(640);
      height_r <= CFG_W'(480);
      limit_r  <= CFG_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        REG_LIMIT:  limit_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // saturated sizes and limit
  logic [CFG_W-1:0] wsat, hsat, lsat, size, sm1;
  logic [DIM_BITS-1:0] idx, idx_c;
  logic [DIM_BITS+1:0] idx3;
  logic small_w, small_h;
  assign wsat = (width_r > DIM_CAP) ? DIM_CAP : width_r;
  assign hsat = (height_r > DIM_CAP) ? DIM_CAP : height_r;
  assign lsat = (limit_r > ITER_CAP) ? ITER_CAP : limit_r;
  assign small_w = wsat <= CFG_W'(1);
  assign small_h = hsat <= CFG_W'(1);

  // divider operands
  assign size  = (cmd.div_sel == DIV_X) ? wsat : hsat;
  assign sm1   = size - 1'b1;
  assign idx   = (cmd.div_sel == DIV_X) ? col_r : row_r;
  assign idx_c = ({1'b0, idx} > sm1) ? sm1[DIM_BITS-1:0] : idx;
  assign idx3  = {1'b0, idx_c, 1'b0} + {2'b00, idx_c};

  logic [NUM_W-1:0] div_num, quot;
  logic [DEN_W-1:0] div_den;
  logic [CNT_W+7:0] scaled;
  assign scaled = {count_r, 8'd0} - {8'd0, count_r};

  always_comb begin
    if (cmd.div_sel == DIV_SCALE) begin
      div_num = NUM_W'(scaled);
      div_den = lsat;
    end else begin
      div_num = {idx3, {FRAC_BITS{1'b0}}};
      div_den = sm1;
    end
  end

  mep_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  // shared multiplier on magnitudes, truncated toward zero
  logic [MAG_W-1:0] zr_mag, zi_mag, zr2_mag, ma, mb;
  logic [2*MAG_W-1:0] prod;
  logic [T_W-1:0] trunc;
  logic neg;
  logic signed [P_W-1:0] sprod;
  logic signed [Z_W:0] zr2;
  assign zr2     = {zr_r, 1'b0};
  assign zr_mag  = zr_r[Z_W-1] ? MAG_W'(-zr_r) : MAG_W'(zr_r);
  assign zi_mag  = zi_r[Z_W-1] ? MAG_W'(-zi_r) : MAG_W'(zi_r);
  assign zr2_mag = zr2[Z_W] ? MAG_W'(-zr2) : MAG_W'(zr2);

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_RR: begin ma = zr_mag;  mb = zr_mag; neg = 1'b0; end
      MUL_II: begin ma = zi_mag;  mb = zi_mag; neg = 1'b0; end
      MUL_RI: begin ma = zr2_mag; mb = zi_mag; neg = zr_r[Z_W-1] ^ zi_r[Z_W-1]; end
      default: begin ma = zr_mag; mb = zr_mag; neg = 1'b0; end
    endcase
  end

  assign prod  = ma * mb;
  assign trunc = prod[2*MAG_W-1:FRAC_BITS];
  assign sprod = neg ? -$signed({1'b0, trunc}) : $signed({1'b0, trunc});

  // escape test and iteration count
  logic signed [P_W:0] mag2;
  assign mag2       = {rr_r[P_W-1], rr_r} + {ii_r[P_W-1], ii_r};
  assign escape     = mag2 > BOUND;
  assign count_full = count_r >= lsat;
  assign status     = '{div_done: div_done, escape: escape, count_full: count_full};

  // point, orbit and product registers
  logic signed [P_W-1:0] nr, ni;
  assign nr = rr_r - ii_r + P_W'(cr_r);
  assign ni = ri_r + P_W'(ci_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r   <= in_pixel_column;
      row_r   <= in_pixel_row;
      zr_r    <= '0;
      zi_r    <= '0;
      count_r <= '0;
    end
    if (cmd.store_x)
      cr_r <= CR_BASE + (small_w ? Z_W'(0) : Z_W'(quot[Q_W-1:0]));
    if (cmd.store_y)
      ci_r <= CI_BASE + (small_h ? Z_W'(0) : Z_W'(quot[Q_W-1:0]));
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        MUL_RR: rr_r <= sprod;
        MUL_II: ii_r <= sprod;
        MUL_RI: ri_r <= sprod;
        default: ;
      endcase
    end
    if (cmd.z_update) begin
      zr_r    <= nr[Z_W-1:0];
      zi_r    <= ni[Z_W-1:0];
      count_r <= count_r + 1'b1;
    end
    if (cmd.out_load)
      gray_r <= (lsat == '0) ? 8'd0 : quot[7:0];
  end

  assign out_gray_level = gray_r;

endmodule

@@ design/mep_ctrl.sv @@
// sequencer for divisions, iterations and the result register
module mep_ctrl import mep_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd,
  output state_t  state
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   free;

  // result register may be written when empty or draining
  assign free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DX;
      ST_DX:   state_nxt = ST_DXW;
      ST_DXW:  if (status.div_done) state_nxt = ST_DY;
      ST_DY:   state_nxt = ST_DYW;
      ST_DYW:  if (status.div_done) state_nxt = ST_IR;
      ST_IR:   state_nxt = status.count_full ? ST_SC : ST_II;
      ST_II:   state_nxt = ST_RI;
      ST_RI:   state_nxt = status.escape ? ST_SC : ST_UP;
      ST_UP:   state_nxt = ST_IR;
      ST_SC:   state_nxt = ST_SCW;
      ST_SCW:  if (status.div_done) state_nxt = ST_FIN;
      ST_FIN:  if (free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd = '0;
    cmd.div_sel = DIV_X;
    cmd.mul_sel = MUL_RR;
    unique case (state_r)
      ST_IDLE: cmd.load = in_valid;
      ST_DX:   cmd.div_start = 1'b1;
      ST_DXW:  cmd.store_x = status.div_done;
      ST_DY:   begin cmd.div_start = 1'b1; cmd.div_sel = DIV_Y; end
      ST_DYW:  begin cmd.div_sel = DIV_Y; cmd.store_y = status.div_done; end
      ST_IR:   cmd.mul_en = !status.count_full;
      ST_II:   begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_II; end
      ST_RI:   begin cmd.mul_en = !status.escape; cmd.mul_sel = MUL_RI; end
      ST_UP:   cmd.z_update = 1'b1;
      ST_SC:   begin cmd.div_start = 1'b1; cmd.div_sel = DIV_SCALE; end
      ST_SCW:  cmd.div_sel = DIV_SCALE;
      ST_FIN:  begin cmd.div_sel = DIV_SCALE; cmd.out_load = free; end
      default: ;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign state     = state_r;

endmodule

@@ design/mandelbrot_escape_pixel_unit.sv @@
// top level of the mandelbrot escape pixel unit
// Usage:
//   in_valid/in_stall carries one request: in_pixel_column and in_pixel_row.
//   out_valid/out_stall returns one out_gray_level for every request, in order.
//   cfg_we/cfg_index/cfg_wdata writes image_width (0), image_height (1) and
//   iteration_limit (2); write only while no request is in flight.
// Timing:
//   one request at a time; in_stall is high from acceptance until the result
//   is written into the output register; the next request is taken in the following cycle.
//   the loop ends in ST_IR when the limit is reached and in ST_RI on escape;
//   each iteration runs ST_IR, ST_II, ST_RI and ST_UP on the single shared 32x32
//   multiplier, and each division (x, y and the final scaling) is a start state
//   and a wait state on the bit-serial restoring divider.
// Reset:
//   synchronous, active low; registers return to 640, 480 and 256, and the
//   output register is empty.
// Stall:
//   a finished result waits in the output register while out_stall is high;
//   a new request is taken meanwhile and waits at its end until the register
//   frees up.
`include "mandelbrot_escape_pixel_unit_defines.svh"
module mandelbrot_escape_pixel_unit import mep_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [DIM_BITS-1:0] in_pixel_column,
  input  logic [DIM_BITS-1:0] in_pixel_row,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_gray_level
);

  cmd_t    cmd;
  status_t status;
  state_t  state;

  mep_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .state     (state)
  );

  mep_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_pixel_column (in_pixel_column),
    .in_pixel_row    (in_pixel_row),
    .cmd             (cmd),
    .status          (status),
    .out_gray_level  (out_gray_level)
  );

  // checks on the sequencing
  `MEP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `MEP_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !(out_valid && out_stall))
  `MEP_ASSERT_IMPL(a_done_when_waiting, status.div_done,
                   state == ST_DXW || state == ST_DYW || state == ST_SCW)

endmodule

@@ bench/tb_mandelbrot_escape_pixel_unit.sv @@
// testbench for the mandelbrot escape pixel unit with its own gray level predictor
`timescale 1ns / 1ps
module tb_mandelbrot_escape_pixel_unit import mep_pkg::*; ();

  localparam longint CYCLE_LIMIT = 40_000_000;
  // index with no register behind it
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]    cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic [DIM_BITS-1:0] in_pixel_column;
  logic [DIM_BITS-1:0] in_pixel_row;
  logic                out_valid;
  logic                out_stall;
  logic [7:0]          out_gray_level;

  typedef struct packed {
    logic [DIM_BITS-1:0] column;
    logic [DIM_BITS-1:0] row;
  } pixel_t;

  pixel_t     pixel_queue[$];
  logic [7:0] gray_queue[$];

  // predictor copy of the registers
  logic [CFG_W-1:0] width_reg, height_reg, limit_reg;

  int     mismatches;
  longint cycle_count;
  int     sender_idle_pct;
  int     receiver_stall_pct;
  int     hold_request;
  int     hold_seen;
  int     hold_left;

  mandelbrot_escape_pixel_unit uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pixel_column(in_pixel_column), .in_pixel_row(in_pixel_row),
    .out_valid(out_valid), .out_stall(out_stall), .out_gray_level(out_gray_level)
  );

  // signed fixed point product, truncated toward zero
  function automatic longint fix_product(longint a, longint b);
    logic              neg;
    logic [127:0]      ua, ub, prod;
    longint unsigned   mag;
    neg  = (a < 0) != (b < 0);
    ua   = 128'(a < 0 ? -a : a);
    ub   = 128'(b < 0 ? -b : b);
    prod = ua * ub;
    mag  = 64'(prod >> FRAC_BITS) & ((64'd1 << 62) - 1);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // offset 3*index/(size-1) from the low end of the range
  function automatic longint coord_offset(longint unsigned index, longint unsigned size);
    if (size > (64'd1 << DIM_BITS)) size = 64'd1 << DIM_BITS;
    if (size <= 1) return 0;
    if (index > size - 1) index = size - 1;
    return longint'(((64'd3 * index) << FRAC_BITS) / (size - 1));
  endfunction

  function automatic logic [7:0] escape_gray(pixel_t px);
    longint one, cr, ci, zr, zi, rr, ii, nr;
    longint unsigned limit, count;
    one   = longint'(1) << FRAC_BITS;
    limit = limit_reg;
    count = 0;
    zr    = 0;
    zi    = 0;
    if (limit > (64'd1 << ITER_BITS)) limit = 64'd1 << ITER_BITS;
    cr = -2 * one + coord_offset(px.column, width_reg);
    ci = -(one + one / 2) + coord_offset(px.row, height_reg);
    while (count < limit) begin
      rr = fix_product(zr, zr);
      ii = fix_product(zi, zi);
      if (rr + ii > 4 * one) break;
      nr = rr - ii + cr;
      zi = fix_product(zr * 2, zi) + ci;
      zr = nr;
      count++;
    end
    if (limit == 0) return 8'd0;
    return 8'((count * 255) / limit);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // clock
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // driver: pulls requests from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pixel_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        pixel_t px;
        px = pixel_queue.pop_front();
        in_valid        <= 1'b1;
        in_pixel_column <= px.column;
        in_pixel_row    <= px.row;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall with a long hold-off on request
  always @(posedge clk) begin
    if (hold_request != hold_seen) begin
      hold_seen <= hold_request;
      hold_left <= 3000;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // monitor: predict on request, check on result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        gray_queue.push_back(escape_gray({in_pixel_column, in_pixel_row}));
      if (out_valid && !out_stall) begin
        if (gray_queue.size() == 0) begin
          report_mismatch("unexpected result", out_gray_level, -1);
        end else begin
          logic [7:0] want;
          want = gray_queue.pop_front();
          if (out_gray_level !== want) report_mismatch("gray_level", out_gray_level, want);
        end
      end
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    case (idx)
      REG_WIDTH:  width_reg  = CFG_W'(value);
      REG_HEIGHT: height_reg = CFG_W'(value);
      REG_LIMIT:  limit_reg  = CFG_W'(value);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sample at the falling edge, where the driver and monitor have settled
  task automatic wait_drained();
    while (pixel_queue.size() > 0 || in_valid || gray_queue.size() > 0) @(negedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic push_pixel(int column, int row);
    pixel_queue.push_back({DIM_BITS'(column), DIM_BITS'(row)});
  endtask

  // random pixels, mostly inside the image
  task automatic push_random(int count);
    int wmax, hmax;
    wmax = (width_reg > 4096) ? 4095 : ((width_reg == 0) ? 0 : width_reg - 1);
    hmax = (height_reg > 4096) ? 4095 : ((height_reg == 0) ? 0 : height_reg - 1);
    repeat (count) begin
      if ($urandom_range(9) < 8) push_pixel($urandom_range(wmax), $urandom_range(hmax));
      else push_pixel($urandom_range(4095), $urandom_range(4095));
    end
  endtask

  task automatic run_phase(int w, int h, int lim, int count, int idle_pct, int stall_pct);
    wait_drained();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_LIMIT, lim);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    push_random(count);
  endtask

  // stimulus
  initial begin
    rst_n = 0; cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    in_valid = 0; in_pixel_column = '0; in_pixel_row = '0; out_stall = 0;
    mismatches = 0; cycle_count = 0; hold_request = 0; hold_seen = 0; hold_left = 0;
    sender_idle_pct = 0; receiver_stall_pct = 0;
    width_reg = 640; height_reg = 480; limit_reg = 256;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, corners, interior, indexes past the edge
    push_pixel(0, 0);
    push_pixel(639, 479);
    push_pixel(320, 240);
    push_pixel(4095, 4095);
    push_pixel(639, 0);
    push_pixel(2730, 1365);
    push_pixel(426, 240);
    wait_drained();
    // sizes of zero and one pin the coordinate, limit of zero gives zero
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 0);
    write_reg(REG_LIMIT, 0);
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    wait_drained();
    write_reg(REG_LIMIT, 1);
    push_pixel(5, 9);
    wait_drained();
    // oversized sizes and limit saturate; write to a missing register is ignored
    write_reg(REG_WIDTH, 8191);
    write_reg(REG_HEIGHT, 8191);
    write_reg(REG_LIMIT, 8191);
    write_reg(REG_UNUSED, 5);
    push_pixel(4095, 0);
    push_pixel(4095, 4095);
    push_pixel(4095, 2048);
    wait_drained();
    write_reg(REG_WIDTH, 4096);
    write_reg(REG_HEIGHT, 4096);
    write_reg(REG_LIMIT, 4096);
    push_pixel(4095, 1000);
    push_pixel(3000, 0);
    push_pixel(2048, 4095);

    // random phases across idling patterns and settings
    run_phase(640, 480, 32, 120, 0, 0);
    run_phase($urandom_range(2, 4096), $urandom_range(2, 4096), $urandom_range(1, 64),
              120, 66, 0);
    run_phase($urandom_range(2, 300), $urandom_range(2, 300), $urandom_range(1, 48),
              120, 0, 66);
    run_phase(4096, 4096, $urandom_range(1, 40), 120, 33, 33);
    // long receiver hold-off while requests keep coming
    run_phase(64, 64, 16, 60, 0, 0);
    hold_request = 1;
    push_random(60);
    // sender pause until everything has come back
    wait_drained();
    push_random(60);
    run_phase(1, 4096, 20, 80, 33, 33);
    run_phase(4096, 1, 20, 80, 66, 0);
    run_phase($urandom_range(2, 100), $urandom_range(2, 100), 256, 40, 0, 66);
    run_phase($urandom_range(1, 8191), $urandom_range(1, 8191), $urandom_range(1, 30),
              100, 33, 33);
    run_phase(3, 3, 8, 90, 0, 0);
    wait_drained();

    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/mep_pkg.sv
design/mep_div.sv
design/mep_datapath.sv
design/mep_ctrl.sv
design/mandelbrot_escape_pixel_unit.sv
bench/tb_mandelbrot_escape_pixel_unit.sv
